// ----- design/dll_pkg.sv -----
// Shared types and constants for the doubly linked list manager.
// No dependencies; used by dll_cell and doubly_linked_list_manager.
`default_nettype none

package dll_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    OP_FRONT  = 2'd0,
    OP_BACK   = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Broadcast command seen by every cell in the apply cycle.
  typedef struct packed {
    op_t              kind;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // Contents of one list slot as handed between neighbors.
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

`default_nettype wire

// ----- design/dll_cell.sv -----
// One slot of the ordered list chain: holds a value and an occupied flag.
// Depends on dll_pkg.
`default_nettype none

module dll_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           apply,
  input  wire dll_pkg::cmd_t  cmd,
  input  wire dll_pkg::slot_t left,      // neighbor toward the head
  input  wire dll_pkg::slot_t right,     // neighbor toward the tail
  input  wire logic           found_in,  // a match exists nearer the head
  output dll_pkg::slot_t      slot,
  output logic                found_out
);

  logic hit;

  assign hit       = slot.valid && (slot.value == cmd.value);
  assign found_out = found_in || hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (apply) begin
      case (cmd.kind)
        dll_pkg::OP_FRONT: begin
          slot <= left;                       // whole list moves one slot back
        end
        dll_pkg::OP_BACK: begin
          if (!slot.valid && left.valid) begin  // first empty slot takes it
            slot.valid <= 1'b1;
            slot.value <= cmd.value;
          end
        end
        dll_pkg::OP_DELETE: begin
          if (found_in || hit) begin          // close the gap from the tail side
            slot <= right;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/doubly_linked_list_manager.sv -----
// Top level of the doubly linked list manager: handshake, control and the cell chain.
// Depends on dll_pkg and dll_cell.
//
//  channel | signals                                  | dir | word
//  --------+------------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, operation, value     | in  | one request
//  out     | out_valid, out_ready, status, entry_count| out | status and count after it
//
// Each request is first captured, then applied in a cycle in which every cell of the
// chain updates at once from its neighbors (shift toward tail on front insert,
// fill first empty slot on back insert, close the gap on delete).
// The result sits in an output register; a new request is taken while it waits,
// but the apply cycle holds until the output register is free.
// Synchronous reset empties the list directly; no clearing pass.
`default_nettype none

module doubly_linked_list_manager (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [4:0]              entry_count
);

  localparam int N = dll_pkg::CAPACITY;

  // captured request
  logic                      busy;
  logic [1:0]                req_op;
  logic [dll_pkg::VAL_W-1:0] req_value;

  logic [dll_pkg::CNT_W-1:0] count;
  logic [dll_pkg::CNT_W-1:0] count_next;
  dll_pkg::status_t          stat_next;

  logic                      fire;
  logic                      full;
  dll_pkg::cmd_t             cmd;

  dll_pkg::slot_t            slots [N];
  logic [N:0]                found;
  logic [N-1:0]              occupied;

  assign in_ready = !busy;
  assign fire     = busy && (!out_valid || out_ready);
  assign full     = (count == dll_pkg::CNT_W'(N));

  // Command broadcast to the chain; refused inserts become no-ops.
  always_comb begin
    cmd.value = req_value;
    case (req_op)
      2'(dll_pkg::OP_FRONT):  cmd.kind = full ? dll_pkg::OP_NONE : dll_pkg::OP_FRONT;
      2'(dll_pkg::OP_BACK):   cmd.kind = full ? dll_pkg::OP_NONE : dll_pkg::OP_BACK;
      2'(dll_pkg::OP_DELETE): cmd.kind = dll_pkg::OP_DELETE;
      default:                cmd.kind = dll_pkg::OP_NONE;
    endcase
  end

  // Cell chain, head at index 0. Head's left neighbor is the new value,
  // tail's right neighbor is an empty slot.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dll_pkg::slot_t lnb;
    dll_pkg::slot_t rnb;

    if (i == 0) begin : g_head
      assign lnb = '{valid: 1'b1, value: req_value};
    end else begin : g_mid_l
      assign lnb = slots[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rnb = '{valid: 1'b0, value: '0};
    end else begin : g_mid_r
      assign rnb = slots[i+1];
    end

    dll_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .apply     (fire),
      .cmd       (cmd),
      .left      (lnb),
      .right     (rnb),
      .found_in  (found[i]),
      .slot      (slots[i]),
      .found_out (found[i+1])
    );

    assign occupied[i] = slots[i].valid;
  end

  // Result and count for the request in the apply cycle.
  always_comb begin
    count_next = count;
    case (req_op)
      2'(dll_pkg::OP_FRONT), 2'(dll_pkg::OP_BACK): begin
        if (full) begin
          stat_next = dll_pkg::ST_FULL;
        end else begin
          stat_next  = dll_pkg::ST_DONE;
          count_next = count + 1'b1;
        end
      end
      2'(dll_pkg::OP_DELETE): begin
        if (found[N]) begin
          stat_next  = dll_pkg::ST_DONE;
          count_next = count - 1'b1;
        end else begin
          stat_next = dll_pkg::ST_NOTFOUND;
        end
      end
      default: stat_next = dll_pkg::ST_NOTFOUND;   // undefined selector
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        busy      <= 1'b1;
        req_op    <= operation;
        req_value <= value;
      end else if (fire) begin
        busy <= 1'b0;
      end

      if (fire) begin
        out_valid   <= 1'b1;
        status      <= stat_next;
        entry_count <= count_next;
        count       <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // Count register tracks the occupied slots exactly.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied) == 32'(count))
    else $error("count disagrees with occupied slots");

  // Occupied slots stay packed toward the head.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((occupied & (occupied + 1'b1)) == '0))
    else $error("gap in occupied slots");

  // A full status is only reported with a full pool.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == 2'(dll_pkg::ST_FULL)) |-> (entry_count == 5'(N)))
    else $error("full status with room left");

  // An apply cycle always frees the request slot.
  a_fire_done: assert property (@(posedge clk) disable iff (rst)
    fire |=> (!busy || $past(in_valid && in_ready)))
    else $error("request stuck after apply");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for doubly_linked_list_manager: directed and random requests,
// with random stalls on both channels, checked against a queue-based list predictor.
// Depends on dll_pkg and the design under design/.

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dll_pkg::op_t op;
    logic [31:0]  val;
  } request_t;

  typedef struct {
    dll_pkg::status_t status;
    logic [4:0]       count;
  } answer_t;

  // Requests near the end of the run go out with no idling on either side.
  localparam int CALM_TAIL  = 200;
  localparam int RAND_ITEMS = 1625;
  localparam int BLOCK_LEN  = 60;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         operation;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  doubly_linked_list_manager u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count)
  );

  request_t    send_q[$];     // words still to be driven
  answer_t     answers_due[$]; // predicted results, oldest first
  logic [31:0] chain[$];       // predicted list contents, head first
  logic [31:0] gen_shadow[$];  // list as the generator expects it, for picking delete values
  request_t    on_bus;         // word currently on the input port
  answer_t     got_want;
  logic        in_took;
  int          in_gap;
  int          out_stall;
  int          accepted;
  int          total_items;
  int          err_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walk semantics: insert refused when full, delete removes the first match
  // from the head, unknown selector changes nothing. Count is after the request.
  function automatic answer_t apply_request(ref logic [31:0] lst[$], input request_t r);
    answer_t a;
    int      hit;
    a.status = dll_pkg::ST_DONE;
    hit      = -1;
    case (r.op)
      dll_pkg::OP_FRONT, dll_pkg::OP_BACK: begin
        if (lst.size() >= dll_pkg::CAPACITY) a.status = dll_pkg::ST_FULL;
        else if (r.op == dll_pkg::OP_FRONT) lst.push_front(r.val);
        else lst.push_back(r.val);
      end
      dll_pkg::OP_DELETE: begin
        foreach (lst[i]) if (hit < 0 && lst[i] == r.val) hit = i;
        if (hit < 0) a.status = dll_pkg::ST_NOTFOUND;
        else lst.delete(hit);
      end
      default: a.status = dll_pkg::ST_NOTFOUND;
    endcase
    a.count = 5'(lst.size());
    return a;
  endfunction

  function automatic void queue_word(dll_pkg::op_t op, logic [31:0] val);
    request_t r;
    r.op  = op;
    r.val = val;
    void'(apply_request(gen_shadow, r));
    send_q.push_back(r);
  endfunction

  // Driver: new word or idle burst at the falling edge, held until accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (send_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_q.size() > CALM_TAIL && $urandom_range(0, 99) < 15) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(1, 9) - 1;
      end else begin
        on_bus    = send_q.pop_front();
        in_valid  <= 1'b1;
        operation <= on_bus.op;
        value     <= on_bus.val;
      end
    end
  end

  // Receiver side: ready drops in bursts until the calm tail.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (send_q.size() > CALM_TAIL && $urandom_range(0, 99) < 15) begin
      out_ready <= 1'b0;
      out_stall <= $urandom_range(1, 9) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        answers_due.push_back(apply_request(chain, on_bus));
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("result with no request pending: status %0d, entry_count %0d",
                 status, entry_count);
          err_count++;
        end else begin
          got_want = answers_due.pop_front();
          if (status !== got_want.status) begin
            $error("status: expected %0d, got %0d", got_want.status, status);
            err_count++;
          end
          if (entry_count !== got_want.count) begin
            $error("entry_count: expected %0d, got %0d", got_want.count, entry_count);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [31:0]  pool[6];
    int           ins_pct;
    int           pick;
    dll_pkg::op_t op;
    logic [31:0]  v;

    rst       = 1'b1;
    in_valid  = 1'b0;
    out_ready = 1'b0;
    operation = '0;
    value     = '0;
    in_took   = 1'b0;
    in_gap    = 0;
    out_stall = 0;
    accepted  = 0;
    err_count = 0;

    // Directed: empty-list cases, field extremes at both ends, duplicates,
    // fill to full, refused inserts, deletes at head, next to tail, middle, missing.
    queue_word(dll_pkg::OP_NONE, 32'hFFFF_FFFF);
    queue_word(dll_pkg::OP_DELETE, 32'h0000_0000);
    queue_word(dll_pkg::OP_FRONT, 32'h7FFF_FFFF);
    queue_word(dll_pkg::OP_BACK, 32'h8000_0000);
    queue_word(dll_pkg::OP_FRONT, 32'hFFFF_FFFF);
    queue_word(dll_pkg::OP_BACK, 32'h0000_0000);
    queue_word(dll_pkg::OP_BACK, 32'h5A5A_5A5A);
    for (int i = 1; i <= 10; i++) queue_word(dll_pkg::OP_BACK, i * 32'h1111_1111);
    queue_word(dll_pkg::OP_BACK, 32'h5A5A_5A5A);
    queue_word(dll_pkg::OP_FRONT, 32'hDEAD_BEEF);
    queue_word(dll_pkg::OP_BACK, 32'hDEAD_BEEF);
    queue_word(dll_pkg::OP_DELETE, 32'hFFFF_FFFF);   // head
    queue_word(dll_pkg::OP_DELETE, 32'h5A5A_5A5A);   // first of two copies
    queue_word(dll_pkg::OP_DELETE, 32'hAAAA_AAAA);   // next to tail
    queue_word(dll_pkg::OP_DELETE, 32'h4444_4444);   // middle
    queue_word(dll_pkg::OP_DELETE, 32'h1234_5678);   // not in list
    queue_word(dll_pkg::OP_NONE, 32'h0000_0000);

    // Random: blocks that lean toward inserts or deletes so the list wanders
    // between empty and full; deletes mostly target values really present.
    foreach (pool[i]) pool[i] = $urandom();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 25;
          1:       ins_pct = 50;
          default: ins_pct = 75;
        endcase
        pool[$urandom_range(0, 5)] = $urandom();
        pool[$urandom_range(0, 5)] = $urandom();
      end
      pick = $urandom_range(0, 99);
      v    = ($urandom_range(0, 99) < 70) ? pool[$urandom_range(0, 5)] : $urandom();
      if (pick < 3) begin
        op = dll_pkg::OP_NONE;
      end else if (pick < 3 + ins_pct) begin
        op = $urandom_range(0, 1) ? dll_pkg::OP_BACK : dll_pkg::OP_FRONT;
      end else begin
        op = dll_pkg::OP_DELETE;
        if (gen_shadow.size() > 0 && $urandom_range(0, 99) < 80)
          v = gen_shadow[$urandom_range(0, gen_shadow.size() - 1)];
      end
      queue_word(op, v);
    end
    total_items = send_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted < total_items) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_count == 0) begin
      $display("[doubly_linked_list_manager] OK");
    end else begin
      $display("[doubly_linked_list_manager] ERROR");
    end
    $finish;
  end

  // Timeout set well beyond the slowest run.
  initial begin
    #5_000_000;
    $display("[doubly_linked_list_manager] ERROR");
    $finish;
  end

endmodule
